// ===== hw/rtl/srt_pkg.sv =====
// Shared types and codes for the symbol range table.
package srt_pkg;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_INC    = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_ACCUM  = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] start_tick;
    logic [ADDR_W-1:0] acc_time;
  } entry_t;

  typedef struct packed {
    logic region;
    logic count;
    logic start_tick;
    logic acc_time;
  } wr_en_t;

endpackage

// ===== hw/rtl/symbol_range_table_with_profiling.sv =====
// Top level: request sequencer around the entry store and the compare unit.
//
//  Channel   Signals                                        Beat taken when
//  request   start, busy, action, address, region_size,     start && !busy
//            tick_value
//  result    done, hit, entry_index, table_full,            done (one cycle)
//            entries_used, hit_count, hit_time
//
// Add and unknown actions are answered from idle, with done in the next cycle.
// Lookup and the profiling requests scan the used entries one per cycle
// through the single memory read port and the shared compare unit; for the
// profiling requests an exact match stops the scan early.
// Reset clears the fill count and the sequencer control; an add writes all
// fields of its slot, so no clearing pass runs. The receiver cannot stall:
// each result shows for exactly one cycle.
module symbol_range_table_with_profiling
  import srt_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action,
  input  logic [ADDR_W-1:0] address,
  input  logic [ADDR_W-1:0] region_size,
  input  logic [ADDR_W-1:0] tick_value,
  output logic              done,
  output logic              hit,
  output logic [7:0]        entry_index,
  output logic              table_full,
  output logic [8:0]        entries_used,
  output logic [CNT_W-1:0]  hit_count,
  output logic [ADDR_W-1:0] hit_time
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DELTA = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     fill;
  logic [2:0]        act;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] req_tick;
  logic [CW-1:0]     issue_idx;
  logic              rd_valid;
  logic [IW-1:0]     rd_idx;
  logic              found;
  logic [IW-1:0]     found_idx;
  logic [ADDR_W-1:0] delta;

  logic              accept;
  logic              issue;
  logic              range_mode;
  logic              match;
  logic              has_room;
  wr_en_t            wr_en;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     raddr;
  entry_t            wdata;
  entry_t            rdata;
  logic [CNT_W-1:0]  new_count;
  logic [ADDR_W-1:0] new_acc;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign issue      = (issue_idx < fill);
  assign range_mode = (act == ACT_LOOKUP);
  assign has_room   = (fill < CW'(ENTRIES));
  assign raddr      = (state == S_SCAN) ? issue_idx[IW-1:0] : found_idx;

  srt_match u_match (
    .range_mode (range_mode),
    .address    (req_addr),
    .base       (rdata.base),
    .size       (rdata.size),
    .match      (match)
  );

  srt_table #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Updated profiling values for the matched entry.
  always_comb begin
    new_count = rdata.count;
    new_acc   = rdata.acc_time;
    unique case (act)
      ACT_INC:   new_count = rdata.count + 1'b1;
      ACT_ACCUM: new_acc   = rdata.acc_time + delta;
      default: begin
      end
    endcase
  end

  // Write port: an add fills a whole slot; increment and start update one field, accumulate two.
  always_comb begin
    wr_en = '0;
    waddr = found_idx;
    wdata = rdata;
    wdata.count    = new_count;
    wdata.acc_time = new_acc;
    if (state == S_IDLE) begin
      waddr            = fill[IW-1:0];
      wdata.base       = address;
      wdata.size       = region_size;
      wdata.count      = '0;
      wdata.start_tick = '0;
      wdata.acc_time   = '0;
      if (accept && action == ACT_ADD && has_room) begin
        wr_en = '{region: 1'b1, count: 1'b1, start_tick: 1'b1, acc_time: 1'b1};
      end
    end else if (state == S_APPLY) begin
      unique case (act)
        ACT_INC: begin
          wr_en.count = 1'b1;
        end
        ACT_START: begin
          wr_en.start_tick = 1'b1;
          wdata.start_tick = req_tick;
        end
        ACT_ACCUM: begin
          wr_en.acc_time   = 1'b1;
          wr_en.start_tick = 1'b1;
          wdata.start_tick = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_ADD) begin
              done <= 1'b1;
              if (has_room) begin
                fill <= fill + 1'b1;
              end
            end else if (action == ACT_LOOKUP || action == ACT_INC ||
                         action == ACT_START || action == ACT_ACCUM) begin
              state <= S_SCAN;
              found <= 1'b0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          rd_valid <= issue;
          if (rd_valid && match) begin
            found <= 1'b1;
          end
          if (rd_valid && match && !range_mode) begin
            rd_valid <= 1'b0;
            state    <= S_FETCH;
          end else if (!issue && !rd_valid) begin
            if (found) begin
              state <= S_FETCH;
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          state <= (act == ACT_ACCUM) ? S_DELTA : S_APPLY;
        end
        S_DELTA: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request hold, scan index and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          act          <= action;
          req_addr     <= address;
          req_tick     <= tick_value;
          issue_idx    <= '0;
          hit          <= 1'b0;
          entry_index  <= '0;
          table_full   <= 1'b0;
          entries_used <= 9'(fill);
          hit_count    <= '0;
          hit_time     <= '0;
          if (action == ACT_ADD) begin
            if (has_room) begin
              hit          <= 1'b1;
              entry_index  <= 8'(fill);
              entries_used <= 9'(fill + 1'b1);
            end else begin
              table_full <= 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          issue_idx <= issue_idx + 1'b1;
        end
        rd_idx <= issue_idx[IW-1:0];
        if (rd_valid && match) begin
          found_idx <= rd_idx;
        end
      end
      S_DELTA: begin
        delta <= req_tick - rdata.start_tick;
      end
      S_APPLY: begin
        hit         <= 1'b1;
        entry_index <= 8'(found_idx);
        hit_count   <= new_count;
        hit_time    <= new_acc;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/srt_match.sv =====
// Shared compare unit: exact base match or range containment (a range that wraps past the top never matches).
module srt_match
  import srt_pkg::*;
(
  input  logic              range_mode,
  input  logic [ADDR_W-1:0] address,
  input  logic [ADDR_W-1:0] base,
  input  logic [ADDR_W-1:0] size,
  output logic              match
);

  logic [ADDR_W-1:0] limit;

  assign limit = base + size;

  always_comb begin
    if (range_mode) begin
      match = (size != '0) && (address >= base) && (address < limit);
    end else begin
      match = (address == base);
    end
  end

endmodule

// ===== hw/rtl/srt_table.sv =====
// Entry store: region and profiling memories, one write and one read port.
module srt_table
  import srt_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int IW      = 8
) (
  input  logic          clk,
  input  wr_en_t        wr_en,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  logic [ADDR_W-1:0] base_mem  [ENTRIES];
  logic [ADDR_W-1:0] size_mem  [ENTRIES];
  logic [CNT_W-1:0]  count_mem [ENTRIES];
  logic [ADDR_W-1:0] start_mem [ENTRIES];
  logic [ADDR_W-1:0] acc_mem   [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en.region) begin
      base_mem[waddr] <= wdata.base;
      size_mem[waddr] <= wdata.size;
    end
    if (wr_en.count) begin
      count_mem[waddr] <= wdata.count;
    end
    if (wr_en.start_tick) begin
      start_mem[waddr] <= wdata.start_tick;
    end
    if (wr_en.acc_time) begin
      acc_mem[waddr] <= wdata.acc_time;
    end
  end

  always_ff @(posedge clk) begin
    rdata.base       <= base_mem[raddr];
    rdata.size       <= size_mem[raddr];
    rdata.count      <= count_mem[raddr];
    rdata.start_tick <= start_mem[raddr];
    rdata.acc_time   <= acc_mem[raddr];
  end

endmodule

// ===== dv/symbol_range_table_with_profiling_tb.sv =====
// Testbench for symbol_range_table_with_profiling: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module symbol_range_table_with_profiling_tb
  import srt_pkg::*;
();

  typedef struct packed {
    logic              hit;
    logic [7:0]        entry_index;
    logic              table_full;
    logic [8:0]        entries_used;
    logic [CNT_W-1:0]  hit_count;
    logic [ADDR_W-1:0] hit_time;
  } table_reply_t;

  class range_table_scoreboard #(int DEPTH = 256);
    int                fill_count;
    logic [ADDR_W-1:0] slot_base [DEPTH];
    logic [ADDR_W-1:0] slot_size [DEPTH];
    logic [CNT_W-1:0]  slot_calls[DEPTH];
    logic [ADDR_W-1:0] slot_start[DEPTH];
    logic [ADDR_W-1:0] slot_time [DEPTH];
    table_reply_t      replies_due[$];
    int                failures;

    function new();
      fill_count = 0;
      failures   = 0;
      foreach (slot_base[i]) begin
        slot_base[i]  = '0;
        slot_size[i]  = '0;
        slot_calls[i] = '0;
        slot_start[i] = '0;
        slot_time[i]  = '0;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // First stored entry whose base equals the address, or -1.
    function int first_exact(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < fill_count; i++)
        if (slot_base[i] == addr) return i;
      return -1;
    endfunction

    // Update the table copy for one accepted beat and queue its reply.
    function void note_request(logic [2:0] act, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] tick);
      int                idx;
      logic              dropped;
      logic [ADDR_W-1:0] range_end;
      table_reply_t      want;
      idx     = -1;
      dropped = 1'b0;
      case (act)
        ACT_ADD: begin
          if (fill_count < DEPTH) begin
            idx = fill_count;
            slot_base[idx]  = addr;
            slot_size[idx]  = size;
            slot_calls[idx] = '0;
            slot_start[idx] = '0;
            slot_time[idx]  = '0;
            fill_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        ACT_LOOKUP: begin
          for (int i = 0; i < fill_count; i++) begin
            range_end = slot_base[i] + slot_size[i];
            if (slot_size[i] != 0 && addr >= slot_base[i] && addr < range_end) idx = i;
          end
        end
        ACT_INC: begin
          idx = first_exact(addr);
          if (idx >= 0) slot_calls[idx] = slot_calls[idx] + 1'b1;
        end
        ACT_START: begin
          idx = first_exact(addr);
          if (idx >= 0) slot_start[idx] = tick;
        end
        ACT_ACCUM: begin
          idx = first_exact(addr);
          if (idx >= 0) begin
            slot_time[idx]  = slot_time[idx] + (tick - slot_start[idx]);
            slot_start[idx] = '0;
          end
        end
        default: ;
      endcase
      want.hit          = (idx >= 0);
      want.entry_index  = (idx >= 0) ? idx[7:0] : 8'd0;
      want.table_full   = dropped;
      want.entries_used = fill_count[8:0];
      want.hit_count    = (idx >= 0) ? slot_calls[idx] : '0;
      want.hit_time     = (idx >= 0) ? slot_time[idx] : '0;
      replies_due.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected %0h, actual %0h", field, want, got);
      end
    endfunction

    function void check_result(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        failures++;
        $error("result beat with no request outstanding");
        return;
      end
      want = replies_due.pop_front();
      compare_field("hit", 64'(want.hit), 64'(got.hit));
      compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
      compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
      compare_field("entries_used", 64'(want.entries_used), 64'(got.entries_used));
      compare_field("hit_count", 64'(want.hit_count), 64'(got.hit_count));
      compare_field("hit_time", want.hit_time, got.hit_time);
    endfunction
  endclass

  localparam int TABLE_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 1000;
  // Region where most new bases land, so ranges overlap and stack up.
  localparam logic [ADDR_W-1:0] CLUSTER_BASE = 64'h0000_7F00_0000_0000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        action = ACT_ADD;
  logic [ADDR_W-1:0] address = '0;
  logic [ADDR_W-1:0] region_size = '0;
  logic [ADDR_W-1:0] tick_value = '0;
  logic              done;
  logic              hit;
  logic [7:0]        entry_index;
  logic              table_full;
  logic [8:0]        entries_used;
  logic [CNT_W-1:0]  hit_count;
  logic [ADDR_W-1:0] hit_time;

  range_table_scoreboard #(TABLE_DEPTH) sb;

  // Bases and sizes of the entries the table holds, for aiming requests at them.
  logic [ADDR_W-1:0] stored_bases[$];
  logic [ADDR_W-1:0] stored_sizes[$];
  logic [ADDR_W-1:0] tick_clock = 64'd1000;
  // Keep start up back to back while set; otherwise draw a gap per beat.
  bit                steady_sender = 1'b0;
  table_reply_t      seen_reply;

  symbol_range_table_with_profiling #(.ENTRIES(TABLE_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .address      (address),
    .region_size  (region_size),
    .tick_value   (tick_value),
    .done         (done),
    .hit          (hit),
    .entry_index  (entry_index),
    .table_full   (table_full),
    .entries_used (entries_used),
    .hit_count    (hit_count),
    .hit_time     (hit_time)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Take every result beat: done marks it for one cycle and it cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_reply.hit          = hit;
      seen_reply.entry_index  = entry_index;
      seen_reply.table_full   = table_full;
      seen_reply.entries_used = entries_used;
      seen_reply.hit_count    = hit_count;
      seen_reply.hit_time     = hit_time;
      sb.check_result(seen_reply);
    end
  end

  // Present one request beat and hold it until the block takes it
  // (start high and busy low at a rising edge). Call only at a rising edge.
  task automatic issue_request(input logic [2:0] act, input logic [ADDR_W-1:0] addr,
                               input logic [ADDR_W-1:0] size,
                               input logic [ADDR_W-1:0] tick);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    address     <= addr;
    region_size <= size;
    tick_value  <= tick;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(act, addr, size, tick);
    if (act == ACT_ADD && stored_bases.size() < TABLE_DEPTH) begin
      stored_bases.push_back(addr);
      stored_sizes.push_back(size);
    end
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_new_base();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return random_word();
    if (roll < 6 || stored_bases.size() == 0) return CLUSTER_BASE + $urandom_range(0, 4095);
    if (roll < 8) return stored_bases[$urandom_range(0, stored_bases.size() - 1)];
    if (roll == 8) return 64'hFFFF_FFFF_FFFF_F000 + $urandom_range(0, 4095);
    return 64'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_region_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll < 7) return 64'($urandom_range(1, 512));
    if (roll == 7) return random_word();
    if (roll == 8) return 64'hFFFF_FFFF_FFFF_0000 + $urandom_range(0, 65535);
    return ($urandom_range(0, 1) != 0) ? 64'd1 : '1;
  endfunction

  // Aim mostly inside stored ranges, some at their edges, the rest anywhere.
  function automatic logic [ADDR_W-1:0] pick_lookup_address();
    int                roll;
    int                k;
    logic [ADDR_W-1:0] span;
    roll = $urandom_range(0, 99);
    if (stored_bases.size() == 0 || roll >= 80)
      return (roll >= 90) ? random_word() : CLUSTER_BASE + $urandom_range(0, 8191);
    k = $urandom_range(0, stored_bases.size() - 1);
    if (roll >= 65)
      return ($urandom_range(0, 1) != 0) ? stored_bases[k] + stored_sizes[k]
                                         : stored_bases[k] - 1'b1;
    span = (stored_sizes[k] > 700) ? 64'd700 : stored_sizes[k];
    if (span == 0) return stored_bases[k];
    return stored_bases[k] + ($urandom % span[31:0]);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_profiled_address();
    if (stored_bases.size() != 0 && $urandom_range(0, 4) != 0)
      return stored_bases[$urandom_range(0, stored_bases.size() - 1)];
    return ($urandom_range(0, 1) != 0) ? random_word() : CLUSTER_BASE + $urandom_range(0, 4095);
  endfunction

  function automatic logic [ADDR_W-1:0] next_tick();
    if ($urandom_range(0, 4) == 0) return random_word();
    tick_clock = tick_clock + $urandom_range(1, 5000);
    return tick_clock;
  endfunction

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("symbol_range_table_with_profiling verification failed");
    $finish;
  end

  initial begin
    int               counted;
    int               roll;
    int               add_pct;
    logic [2:0]       act;
    logic [ADDR_W-1:0] base_pick;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table: a lookup and an increment miss, unknown actions are ignored.
    issue_request(ACT_LOOKUP, '0, '0, '0);
    issue_request(ACT_INC, '0, '0, '0);
    for (int k = 1; k <= 3; k++) issue_request(ACT_ACCUM + 3'(k), '1, '1, '1);

    // Overlapping, zero-size, wrapping and all-ones regions.
    issue_request(ACT_ADD, 64'h1000, 64'h100, '0);
    issue_request(ACT_ADD, 64'h1000, '0, '0);
    issue_request(ACT_ADD, 64'h1080, 64'h40, '0);
    issue_request(ACT_ADD, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, '0);
    issue_request(ACT_ADD, 64'h8000_0000_0000_0000, '1, '0);
    issue_request(ACT_ADD, '1, 64'd1, '0);

    // Range lookups: the last match wins, the exclusive end misses, wrapped ranges miss.
    issue_request(ACT_LOOKUP, 64'h1000, '0, '0);
    issue_request(ACT_LOOKUP, 64'h1090, '0, '0);
    issue_request(ACT_LOOKUP, 64'h10C0, '0, '0);
    issue_request(ACT_LOOKUP, 64'h10FF, '0, '0);
    issue_request(ACT_LOOKUP, 64'h1100, '0, '0);
    issue_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0);
    issue_request(ACT_LOOKUP, 64'h50, '0, '0);
    issue_request(ACT_LOOKUP, '1, '0, '0);

    // Profiling on the first exact match, including time that wraps.
    issue_request(ACT_INC, 64'h1000, '0, '0);
    issue_request(ACT_INC, 64'h1000, '0, '0);
    issue_request(ACT_START, 64'h1000, '0, 64'd100);
    issue_request(ACT_ACCUM, 64'h1000, '0, 64'd50);
    issue_request(ACT_ACCUM, 64'h1000, '0, '1);
    issue_request(ACT_START, 64'h8000_0000_0000_0000, '0, '1);
    issue_request(ACT_ACCUM, 64'h8000_0000_0000_0000, '0, '0);
    issue_request(ACT_INC, '1, '0, '0);

    drain_results();

    // Random phase: fill the table early, then keep hammering a full one.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) steady_sender = ($urandom_range(0, 3) == 0);
      if (counted % 250 == 125) drain_results();
      add_pct = (stored_bases.size() < TABLE_DEPTH) ? 35 : 10;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Ignored action codes; not counted toward the item budget.
        issue_request(ACT_ACCUM + 3'($urandom_range(1, 3)), random_word(), random_word(),
                      random_word());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
          base_pick = pick_new_base();
          issue_request(ACT_ADD, base_pick, pick_region_size(), random_word());
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 45)      act = ACT_LOOKUP;
          else if (roll < 65) act = ACT_INC;
          else if (roll < 83) act = ACT_START;
          else                act = ACT_ACCUM;
          if (act == ACT_LOOKUP)
            issue_request(act, pick_lookup_address(), random_word(), random_word());
          else
            issue_request(act, pick_profiled_address(), random_word(), next_tick());
        end
        counted++;
      end
    end

    // Wait out every result, then a few more cycles for any stray beat.
    drain_results();
    repeat (10) @(posedge clk);
    if (sb.failures == 0)
      $display("symbol_range_table_with_profiling verification clean");
    else
      $display("symbol_range_table_with_profiling verification failed");
    $finish;
  end

endmodule

// ===== symbol_range_table_with_profiling.f =====
hw/rtl/srt_pkg.sv
hw/rtl/srt_match.sv
hw/rtl/srt_table.sv
hw/rtl/symbol_range_table_with_profiling.sv
dv/symbol_range_table_with_profiling_tb.sv
